// ===== src/quaternion_pose_to_rotation_assert.svh =====
// Assertion macros shared by the checker of the pose-to-rotation block.
// Depends on nothing; included by name where concurrent checks are written.
`ifndef QUATERNION_POSE_TO_ROTATION_ASSERT_SVH
`define QUATERNION_POSE_TO_ROTATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPTR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QPTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qptr_pkg.sv =====
// Shared types and constants of the quaternion pose to rotation block.
// Depends on nothing; used by every other file of the block but the assertion header.
`timescale 1ns / 1ps

package qptr_pkg;

    localparam int QW         = 32;
    localparam int NUM_Q      = 4;
    localparam int NUM_T      = 3;
    localparam int ROWS       = 3;
    localparam int ENTRIES    = ROWS * ROWS;
    localparam int PS_W       = 31;
    localparam int PROD_W     = 62;
    localparam int ACC_W      = 64;
    localparam int DIV_STEPS  = 32;
    localparam int MSB_TARGET = 29;
    localparam int FRAC_CUT   = 30;
    localparam int POS_W      = 5;

    typedef logic signed [QW-1:0]     fix_t;
    typedef logic [QW-1:0]            mag_t;
    typedef logic signed [PS_W-1:0]   ps_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [PROD_W-1:0]        nrm_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [ACC_W-1:0]         rem_t;
    typedef logic [QW-1:0]            quo_t;
    typedef logic [1:0]               row_t;
    typedef logic [POS_W-1:0]         pos_t;

    localparam row_t ROW_FIRST = 2'd0;
    localparam row_t ROW_LAST  = 2'd2;

    localparam rem_t ROUND_HALF = rem_t'(1) << (FRAC_CUT - 1);
    localparam rem_t SAT_POS    = rem_t'(64'h0000_0000_7FFF_FFFF);
    localparam rem_t SAT_NEG    = rem_t'(64'h0000_0000_8000_0000);

    // Valid bit and zero-quaternion flag that ride along each stage.
    typedef struct packed {
        logic valid;
        logic zero;
    } tag_t;

    // Flat index of matrix entry (row, col).
    function automatic int ent_idx(input int r, input int c);
        return r * ROWS + c;
    endfunction

endpackage

// ===== src/qptr_if.sv =====
// Handshake channels of the pose-to-rotation block: pose in, matrix rows out.
// Depends on qptr_pkg for the payload types.
`timescale 1ns / 1ps

interface qptr_pose_if;
    logic           valid;
    logic           ready;
    qptr_pkg::fix_t quat_w;
    qptr_pkg::fix_t quat_x;
    qptr_pkg::fix_t quat_y;
    qptr_pkg::fix_t quat_z;
    qptr_pkg::fix_t trans_x;
    qptr_pkg::fix_t trans_y;
    qptr_pkg::fix_t trans_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z,
                    trans_x, trans_y, trans_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z,
                    trans_x, trans_y, trans_z, output ready);
endinterface

interface qptr_row_if;
    logic           valid;
    logic           ready;
    qptr_pkg::row_t row_index;
    qptr_pkg::fix_t entry_col0;
    qptr_pkg::fix_t entry_col1;
    qptr_pkg::fix_t entry_col2;
    qptr_pkg::fix_t centre_component;
    logic           zero_length;
    logic           last_row;

    modport source (output valid, row_index, entry_col0, entry_col1, entry_col2,
                    centre_component, zero_length, last_row, input ready);
    modport sink   (input valid, row_index, entry_col0, entry_col1, entry_col2,
                    centre_component, zero_length, last_row, output ready);
endinterface

// ===== src/qptr_prep.sv =====
// Front end: quaternion prescale, products, norm and matrix numerators.
// Depends on qptr_pkg. Six register stages, all advancing on en.
`timescale 1ns / 1ps

module qptr_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qptr_pkg::fix_t      quat [qptr_pkg::NUM_Q],
    input  qptr_pkg::fix_t      trans [qptr_pkg::NUM_T],
    output qptr_pkg::tag_t      tag_o,
    output qptr_pkg::fix_t      trans_o [qptr_pkg::NUM_T],
    output qptr_pkg::nrm_t      mag_o [qptr_pkg::ENTRIES],
    output logic                neg_o [qptr_pkg::ENTRIES],
    output qptr_pkg::nrm_t      norm_o
);
    import qptr_pkg::*;

    // Stage A: sign and magnitude, largest magnitude.
    tag_t a_tag_reg;
    mag_t a_mag_reg [NUM_Q];
    logic a_neg_reg [NUM_Q];
    mag_t a_max_reg;
    fix_t a_t_reg [NUM_T];
    mag_t mag_next [NUM_Q];
    mag_t max_next;

    always_comb
    begin
        for (int i = 0; i < NUM_Q; i++)
        begin
            mag_next[i] = quat[i][QW-1] ? mag_t'(-quat[i]) : mag_t'(quat[i]);
        end
        max_next = mag_next[0];
        for (int i = 1; i < NUM_Q; i++)
        begin
            if (mag_next[i] > max_next)
            begin
                max_next = mag_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
        end
        else if (en)
        begin
            a_tag_reg.valid <= in_valid;
            a_tag_reg.zero  <= (max_next == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_Q; i++)
            begin
                a_mag_reg[i] <= mag_next[i];
                a_neg_reg[i] <= quat[i][QW-1];
            end
            a_max_reg <= max_next;
            a_t_reg   <= trans;
        end
    end

    // Stage B: leading one of the largest magnitude gives the common shift.
    tag_t b_tag_reg;
    mag_t b_mag_reg [NUM_Q];
    logic b_neg_reg [NUM_Q];
    logic [1:0] b_rs_reg;
    pos_t b_ls_reg;
    fix_t b_t_reg [NUM_T];
    pos_t msb_pos;
    logic [1:0] rs_next;
    pos_t ls_next;

    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < QW; i++)
        begin
            if (a_max_reg[i])
            begin
                msb_pos = pos_t'(i);
            end
        end
        if (msb_pos > pos_t'(MSB_TARGET))
        begin
            rs_next = 2'(msb_pos - pos_t'(MSB_TARGET));
            ls_next = '0;
        end
        else
        begin
            rs_next = '0;
            ls_next = pos_t'(MSB_TARGET) - msb_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_tag_reg <= '0;
        end
        else if (en)
        begin
            b_tag_reg <= a_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_mag_reg <= a_mag_reg;
            b_neg_reg <= a_neg_reg;
            b_rs_reg  <= rs_next;
            b_ls_reg  <= ls_next;
            b_t_reg   <= a_t_reg;
        end
    end

    // Stage C: apply the shift and restore the sign.
    tag_t c_tag_reg;
    ps_t  c_p_reg [NUM_Q];
    fix_t c_t_reg [NUM_T];
    ps_t  p_next [NUM_Q];
    mag_t shifted;

    always_comb
    begin
        shifted = '0;
        for (int i = 0; i < NUM_Q; i++)
        begin
            shifted   = (b_mag_reg[i] >> b_rs_reg) << b_ls_reg;
            p_next[i] = b_neg_reg[i] ? -ps_t'({1'b0, shifted[PS_W-2:0]})
                                     :  ps_t'({1'b0, shifted[PS_W-2:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_tag_reg <= '0;
        end
        else if (en)
        begin
            c_tag_reg <= b_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_p_reg <= p_next;
            c_t_reg <= b_t_reg;
        end
    end

    // Stage D: ten products of the prescaled parts (w, x, y, z).
    tag_t  d_tag_reg;
    prod_t d_ww_reg, d_xx_reg, d_yy_reg, d_zz_reg;
    prod_t d_xy_reg, d_zw_reg, d_xz_reg, d_yw_reg, d_yz_reg, d_xw_reg;
    fix_t  d_t_reg [NUM_T];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_tag_reg <= '0;
        end
        else if (en)
        begin
            d_tag_reg <= c_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ww_reg <= c_p_reg[0] * c_p_reg[0];
            d_xx_reg <= c_p_reg[1] * c_p_reg[1];
            d_yy_reg <= c_p_reg[2] * c_p_reg[2];
            d_zz_reg <= c_p_reg[3] * c_p_reg[3];
            d_xy_reg <= c_p_reg[1] * c_p_reg[2];
            d_zw_reg <= c_p_reg[3] * c_p_reg[0];
            d_xz_reg <= c_p_reg[1] * c_p_reg[3];
            d_yw_reg <= c_p_reg[2] * c_p_reg[0];
            d_yz_reg <= c_p_reg[2] * c_p_reg[3];
            d_xw_reg <= c_p_reg[1] * c_p_reg[0];
            d_t_reg  <= c_t_reg;
        end
    end

    // Stage E: squared norm and the nine numerators (matrix times norm).
    tag_t e_tag_reg;
    acc_t e_num_reg [ENTRIES];
    nrm_t e_norm_reg;
    fix_t e_t_reg [NUM_T];
    acc_t num_next [ENTRIES];
    acc_t ww, xx, yy, zz, norm_next;

    always_comb
    begin
        ww = acc_t'(d_ww_reg);
        xx = acc_t'(d_xx_reg);
        yy = acc_t'(d_yy_reg);
        zz = acc_t'(d_zz_reg);
        norm_next   = ww + xx + yy + zz;
        num_next[0] = ww + xx - yy - zz;
        num_next[1] = (acc_t'(d_xy_reg) - acc_t'(d_zw_reg)) <<< 1;
        num_next[2] = (acc_t'(d_xz_reg) + acc_t'(d_yw_reg)) <<< 1;
        num_next[3] = (acc_t'(d_xy_reg) + acc_t'(d_zw_reg)) <<< 1;
        num_next[4] = ww - xx + yy - zz;
        num_next[5] = (acc_t'(d_yz_reg) - acc_t'(d_xw_reg)) <<< 1;
        num_next[6] = (acc_t'(d_xz_reg) - acc_t'(d_yw_reg)) <<< 1;
        num_next[7] = (acc_t'(d_yz_reg) + acc_t'(d_xw_reg)) <<< 1;
        num_next[8] = ww - xx - yy + zz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_tag_reg <= '0;
        end
        else if (en)
        begin
            e_tag_reg <= d_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_num_reg  <= num_next;
            e_norm_reg <= norm_next[PROD_W-1:0];
            e_t_reg    <= d_t_reg;
        end
    end

    // Stage F: numerator magnitudes and signs for the dividers.
    tag_t f_tag_reg;
    nrm_t f_mag_reg [ENTRIES];
    logic f_neg_reg [ENTRIES];
    nrm_t f_norm_reg;
    fix_t f_t_reg [NUM_T];
    acc_t abs_next [ENTRIES];

    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            abs_next[e] = e_num_reg[e][ACC_W-1] ? -e_num_reg[e] : e_num_reg[e];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_tag_reg <= '0;
        end
        else if (en)
        begin
            f_tag_reg <= e_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                f_mag_reg[e] <= abs_next[e][PROD_W-1:0];
                f_neg_reg[e] <= e_num_reg[e][ACC_W-1];
            end
            f_norm_reg <= e_norm_reg;
            f_t_reg    <= e_t_reg;
        end
    end

    assign tag_o   = f_tag_reg;
    assign trans_o = f_t_reg;
    assign mag_o   = f_mag_reg;
    assign neg_o   = f_neg_reg;
    assign norm_o  = f_norm_reg;

endmodule

// ===== src/qptr_div.sv =====
// Pipelined restoring dividers: nine entries of |num| * 2^30 / norm, one
// quotient bit per stage, then rounding and sign. Depends on qptr_pkg.
`timescale 1ns / 1ps

module qptr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  qptr_pkg::tag_t      tag_i,
    input  qptr_pkg::fix_t      trans_i [qptr_pkg::NUM_T],
    input  qptr_pkg::nrm_t      mag_i [qptr_pkg::ENTRIES],
    input  logic                neg_i [qptr_pkg::ENTRIES],
    input  qptr_pkg::nrm_t      norm_i,
    output qptr_pkg::tag_t      tag_o,
    output qptr_pkg::fix_t      trans_o [qptr_pkg::NUM_T],
    output qptr_pkg::fix_t      entry_o [qptr_pkg::ENTRIES]
);
    import qptr_pkg::*;

    tag_t tag_reg  [DIV_STEPS];
    fix_t t_reg    [DIV_STEPS][NUM_T];
    rem_t r_reg    [DIV_STEPS][ENTRIES];
    quo_t q_reg    [DIV_STEPS][ENTRIES];
    logic neg_reg  [DIV_STEPS][ENTRIES];
    nrm_t d_reg    [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        rem_t r_next [ENTRIES];
        quo_t q_next [ENTRIES];
        rem_t r_shift [ENTRIES];
        quo_t q_shift [ENTRIES];
        rem_t divisor;

        if (s == 0)
        begin : g_first
            // First step compares the unshifted numerator.
            always_comb
            begin
                divisor = rem_t'(norm_i);
                for (int e = 0; e < ENTRIES; e++)
                begin
                    r_shift[e] = rem_t'(mag_i[e]);
                    q_shift[e] = '0;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[s] <= '0;
                end
                else if (en)
                begin
                    tag_reg[s] <= tag_i;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t_reg[s]   <= trans_i;
                    neg_reg[s] <= neg_i;
                    d_reg[s]   <= norm_i;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                divisor = rem_t'(d_reg[s-1]);
                for (int e = 0; e < ENTRIES; e++)
                begin
                    r_shift[e] = r_reg[s-1][e] << 1;
                    q_shift[e] = q_reg[s-1][e] << 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[s] <= '0;
                end
                else if (en)
                begin
                    tag_reg[s] <= tag_reg[s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t_reg[s]   <= t_reg[s-1];
                    neg_reg[s] <= neg_reg[s-1];
                    d_reg[s]   <= d_reg[s-1];
                end
            end
        end

        // Compare and subtract, one quotient bit.
        always_comb
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (r_shift[e] >= divisor)
                begin
                    r_next[e] = r_shift[e] - divisor;
                    q_next[e] = q_shift[e] | quo_t'(1);
                end
                else
                begin
                    r_next[e] = r_shift[e];
                    q_next[e] = q_shift[e];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s] <= r_next;
                q_reg[s] <= q_next;
            end
        end
    end

    // Round half away from zero, restore the sign, zero quaternion gives zero.
    tag_t out_tag_reg;
    fix_t out_t_reg [NUM_T];
    fix_t out_entry_reg [ENTRIES];
    fix_t entry_next [ENTRIES];
    logic [QW:0] rounded;

    always_comb
    begin
        rounded = '0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            rounded = ({1'b0, q_reg[DIV_STEPS-1][e]} + (QW+1)'(1)) >> 1;
            if (tag_reg[DIV_STEPS-1].zero)
            begin
                entry_next[e] = '0;
            end
            else if (neg_reg[DIV_STEPS-1][e])
            begin
                entry_next[e] = -fix_t'(rounded[QW-1:0]);
            end
            else
            begin
                entry_next[e] = fix_t'(rounded[QW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else if (en)
        begin
            out_tag_reg <= tag_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_entry_reg <= entry_next;
            out_t_reg     <= t_reg[DIV_STEPS-1];
        end
    end

    assign tag_o   = out_tag_reg;
    assign trans_o = out_t_reg;
    assign entry_o = out_entry_reg;

endmodule

// ===== src/qptr_centre.sv =====
// Camera centre c = -R^T t: products, sum, magnitude, then rounding to
// Q16.16 with saturation. Depends on qptr_pkg. Four register stages.
`timescale 1ns / 1ps

module qptr_centre (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  qptr_pkg::tag_t      tag_i,
    input  qptr_pkg::fix_t      trans_i [qptr_pkg::NUM_T],
    input  qptr_pkg::fix_t      entry_i [qptr_pkg::ENTRIES],
    output qptr_pkg::tag_t      tag_o,
    output qptr_pkg::fix_t      entry_o [qptr_pkg::ENTRIES],
    output qptr_pkg::fix_t      centre_o [qptr_pkg::ROWS]
);
    import qptr_pkg::*;

    // Stage 1: R[i][k] * t[i] for every column k.
    tag_t p_tag_reg;
    acc_t p_prod_reg [ROWS][NUM_T];
    fix_t p_entry_reg [ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_tag_reg <= '0;
        end
        else if (en)
        begin
            p_tag_reg <= tag_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROWS; k++)
            begin
                for (int i = 0; i < NUM_T; i++)
                begin
                    p_prod_reg[k][i] <= acc_t'(entry_i[ent_idx(i, k)]) *
                                        acc_t'(trans_i[i]);
                end
            end
            p_entry_reg <= entry_i;
        end
    end

    // Stage 2: column sums.
    tag_t s_tag_reg;
    acc_t s_sum_reg [ROWS];
    fix_t s_entry_reg [ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tag_reg <= '0;
        end
        else if (en)
        begin
            s_tag_reg <= p_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROWS; k++)
            begin
                s_sum_reg[k] <= p_prod_reg[k][0] + p_prod_reg[k][1] + p_prod_reg[k][2];
            end
            s_entry_reg <= p_entry_reg;
        end
    end

    // Stage 3: magnitude of the sum; the centre is negative when the sum is positive.
    tag_t m_tag_reg;
    rem_t m_mag_reg [ROWS];
    logic m_neg_reg [ROWS];
    fix_t m_entry_reg [ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tag_reg <= '0;
        end
        else if (en)
        begin
            m_tag_reg <= s_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROWS; k++)
            begin
                m_mag_reg[k] <= s_sum_reg[k][ACC_W-1] ? rem_t'(-s_sum_reg[k])
                                                      : rem_t'(s_sum_reg[k]);
                m_neg_reg[k] <= !s_sum_reg[k][ACC_W-1] && (s_sum_reg[k] != '0);
            end
            m_entry_reg <= s_entry_reg;
        end
    end

    // Stage 4: round half away from zero, saturate.
    tag_t r_tag_reg;
    fix_t r_centre_reg [ROWS];
    fix_t r_entry_reg [ENTRIES];
    fix_t centre_next [ROWS];
    rem_t rnd;

    always_comb
    begin
        rnd = '0;
        for (int k = 0; k < ROWS; k++)
        begin
            rnd = (m_mag_reg[k] + ROUND_HALF) >> FRAC_CUT;
            if (m_neg_reg[k])
            begin
                if (rnd > SAT_NEG)
                begin
                    rnd = SAT_NEG;
                end
                centre_next[k] = -fix_t'(rnd[QW-1:0]);
            end
            else
            begin
                if (rnd > SAT_POS)
                begin
                    rnd = SAT_POS;
                end
                centre_next[k] = fix_t'(rnd[QW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_tag_reg <= '0;
        end
        else if (en)
        begin
            r_tag_reg <= m_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_centre_reg <= centre_next;
            r_entry_reg  <= m_entry_reg;
        end
    end

    assign tag_o    = r_tag_reg;
    assign entry_o  = r_entry_reg;
    assign centre_o = r_centre_reg;

endmodule

// ===== src/qptr_rows.sv =====
// Output stage: holds one finished pose and sends its three rows, one per
// transfer. Depends on qptr_pkg and the row channel interface.
`timescale 1ns / 1ps

module qptr_rows (
    input  logic                clk,
    input  logic                rst_n,
    input  qptr_pkg::tag_t      tag_i,
    input  qptr_pkg::fix_t      entry_i [qptr_pkg::ENTRIES],
    input  qptr_pkg::fix_t      centre_i [qptr_pkg::ROWS],
    output logic                load_ok,
    qptr_row_if.source          rows
);
    import qptr_pkg::*;

    logic busy_reg, busy_next;
    row_t row_reg, row_next;
    logic zero_reg;
    fix_t entry_reg [ENTRIES];
    fix_t centre_reg [ROWS];
    logic load;
    logic take;

    // A new pose may enter when empty or as the last row leaves.
    assign take    = busy_reg && rows.ready;
    assign load_ok = !busy_reg || (take && (row_reg == ROW_LAST));
    assign load    = tag_i.valid && load_ok;

    always_comb
    begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (load)
        begin
            busy_next = 1'b1;
            row_next  = ROW_FIRST;
        end
        else if (take)
        begin
            if (row_reg == ROW_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + row_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= ROW_FIRST;
        end
        else
        begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            zero_reg   <= tag_i.zero;
            entry_reg  <= entry_i;
            centre_reg <= centre_i;
        end
    end

    // Row select of the held pose.
    always_comb
    begin
        case (row_reg)
            ROW_FIRST:
            begin
                rows.entry_col0       = entry_reg[ent_idx(0, 0)];
                rows.entry_col1       = entry_reg[ent_idx(0, 1)];
                rows.entry_col2       = entry_reg[ent_idx(0, 2)];
                rows.centre_component = centre_reg[0];
            end
            ROW_LAST:
            begin
                rows.entry_col0       = entry_reg[ent_idx(2, 0)];
                rows.entry_col1       = entry_reg[ent_idx(2, 1)];
                rows.entry_col2       = entry_reg[ent_idx(2, 2)];
                rows.centre_component = centre_reg[2];
            end
            default:
            begin
                rows.entry_col0       = entry_reg[ent_idx(1, 0)];
                rows.entry_col1       = entry_reg[ent_idx(1, 1)];
                rows.entry_col2       = entry_reg[ent_idx(1, 2)];
                rows.centre_component = centre_reg[1];
            end
        endcase
    end

    assign rows.valid       = busy_reg;
    assign rows.row_index   = row_reg;
    assign rows.zero_length = zero_reg;
    assign rows.last_row    = (row_reg == ROW_LAST);

endmodule

// ===== src/quaternion_pose_to_rotation.sv =====
// Top level: quaternion pose to rotation matrix rows and camera centre.
// Depends on qptr_pkg, qptr_if, qptr_prep, qptr_div, qptr_centre, qptr_rows.
//
//   channel | dir | transfer carries
//   pose    | in  | quat_w..quat_z, trans_x..trans_z (Q16.16)
//   rows    | out | row_index, entry_col0..2 (Q2.30), centre_component, flags
//
// A pose passes 6 prescale/product stages, 33 divider stages and 4 centre
// stages, then waits in the row register, which sends three rows per pose
// and takes the next pose only as the last row of the one before leaves.
// Reset clears only the valid and zero-quaternion flags, the busy flag and the row
// counter. When rows backs up and a finished pose waits at the end of the pipeline,
// the whole pipeline holds.
`timescale 1ns / 1ps

module quaternion_pose_to_rotation (
    input  logic        clk,
    input  logic        rst_n,
    qptr_pose_if.sink   pose,
    qptr_row_if.source  rows
);
    import qptr_pkg::*;

    fix_t quat [NUM_Q];
    fix_t trans [NUM_T];
    logic en;
    logic load_ok;

    tag_t prep_tag;
    fix_t prep_t [NUM_T];
    nrm_t prep_mag [ENTRIES];
    logic prep_neg [ENTRIES];
    nrm_t prep_norm;

    tag_t div_tag;
    fix_t div_t [NUM_T];
    fix_t div_entry [ENTRIES];

    tag_t ctr_tag;
    fix_t ctr_entry [ENTRIES];
    fix_t ctr_centre [ROWS];

    assign quat[0]  = pose.quat_w;
    assign quat[1]  = pose.quat_x;
    assign quat[2]  = pose.quat_y;
    assign quat[3]  = pose.quat_z;
    assign trans[0] = pose.trans_x;
    assign trans[1] = pose.trans_y;
    assign trans[2] = pose.trans_z;

    // Pipeline advances unless a finished pose cannot move into the row stage.
    assign en         = !ctr_tag.valid || load_ok;
    assign pose.ready = en;

    qptr_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pose.valid),
        .quat     (quat),
        .trans    (trans),
        .tag_o    (prep_tag),
        .trans_o  (prep_t),
        .mag_o    (prep_mag),
        .neg_o    (prep_neg),
        .norm_o   (prep_norm)
    );

    qptr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_i    (prep_tag),
        .trans_i  (prep_t),
        .mag_i    (prep_mag),
        .neg_i    (prep_neg),
        .norm_i   (prep_norm),
        .tag_o    (div_tag),
        .trans_o  (div_t),
        .entry_o  (div_entry)
    );

    qptr_centre u_centre (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_i    (div_tag),
        .trans_i  (div_t),
        .entry_i  (div_entry),
        .tag_o    (ctr_tag),
        .entry_o  (ctr_entry),
        .centre_o (ctr_centre)
    );

    qptr_rows u_rows (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_i    (ctr_tag),
        .entry_i  (ctr_entry),
        .centre_i (ctr_centre),
        .load_ok  (load_ok),
        .rows     (rows)
    );

endmodule

// ===== src/qptr_checker.sv =====
// Port-level checks of the row channel of the pose-to-rotation block.
// Depends on qptr_pkg and quaternion_pose_to_rotation_assert.svh; bound to the top.
`timescale 1ns / 1ps
`include "quaternion_pose_to_rotation_assert.svh"

module qptr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           valid,
    input logic           ready,
    input qptr_pkg::row_t row_index,
    input qptr_pkg::fix_t entry_col0,
    input qptr_pkg::fix_t entry_col1,
    input qptr_pkg::fix_t entry_col2,
    input qptr_pkg::fix_t centre_component,
    input logic           zero_length,
    input logic           last_row
);
    import qptr_pkg::*;

    // Row index stays within the matrix, and last_row marks the final row.
    `QPTR_ASSERT_IMPLY(a_row_range, clk, rst_n, valid, row_index <= ROW_LAST, "row index out of range")
    `QPTR_ASSERT_IMPLY(a_last_row, clk, rst_n, valid, last_row == (row_index == ROW_LAST), "last_row does not match row index")

    // After a row other than the last, the next row of the pose follows at once.
    `QPTR_ASSERT_NEXT(a_row_follow, clk, rst_n, valid && ready && !last_row, valid && (row_index == $past(row_index) + row_t'(1)), "rows of a pose not contiguous")

    // A zero quaternion gives all-zero values.
    `QPTR_ASSERT_IMPLY(a_zero_vals, clk, rst_n, valid && zero_length, (entry_col0 == '0) && (entry_col1 == '0) && (entry_col2 == '0) && (centre_component == '0), "zero quaternion with nonzero values")

    // A stalled row holds.
    `QPTR_ASSERT_NEXT(a_stall_hold, clk, rst_n, valid && !ready, valid && $stable(row_index) && $stable(entry_col0) && $stable(centre_component), "stalled row changed")

endmodule

bind quaternion_pose_to_rotation qptr_checker u_qptr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid            (rows.valid),
    .ready            (rows.ready),
    .row_index        (rows.row_index),
    .entry_col0       (rows.entry_col0),
    .entry_col1       (rows.entry_col1),
    .entry_col2       (rows.entry_col2),
    .centre_component (rows.centre_component),
    .zero_length      (rows.zero_length),
    .last_row         (rows.last_row)
);

// ===== sim/tb_quaternion_pose_to_rotation.sv =====
// Testbench of the quaternion pose to rotation block: random and directed poses,
// with a scoreboard that predicts each matrix row and centre component.
// Depends on qptr_pkg, qptr_if and the block's RTL.
`timescale 1ns / 1ps

// Expected row of a pose, as the block should send it.
typedef struct {
    logic [1:0]  row_index;
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] col2;
    logic [31:0] centre;
    logic        zero_length;
    logic        last_row;
} row_expect_t;

class rotation_scoreboard;
    row_expect_t pending_rows[$];
    int          mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Magnitude times 2^30 over the squared norm, rounded half away from zero.
    static function longint norm_ratio(longint num, longint n);
        longint unsigned r;
        longint unsigned d;
        longint unsigned q;
        r = (num < 0) ? longint'(-num) : num;
        d = n;
        q = 0;
        if (r >= d)
        begin
            r = r - d;
            q = 1;
        end
        for (int i = 0; i < 31; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        q = (q + 1) >> 1;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Q18.46 to Q16.16 with rounding and saturation.
    static function longint centre_round(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << 29)) >> 30;
        if (v < 0)
        begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            return -longint'(m);
        end
        if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
        return longint'(m);
    endfunction

    // Predicts the three rows of an accepted pose.
    function void note_pose(logic signed [31:0] qv[4], logic signed [31:0] tv[3]);
        longint          p[4];
        longint unsigned mg[4];
        longint unsigned mx;
        longint          rot[3][3];
        longint          cen[3];
        longint          w2, x2, y2, z2, n, s;
        int              rs, ls;
        logic            is_zero;
        row_expect_t     e;
        mx = 0;
        for (int i = 0; i < 4; i++)
        begin
            p[i] = qv[i];
            mg[i] = (p[i] < 0) ? longint'(-p[i]) : p[i];
            if (mg[i] > mx)
                mx = mg[i];
        end
        is_zero = (mx == 0);
        for (int k = 0; k < 3; k++)
        begin
            cen[k] = 0;
            for (int j = 0; j < 3; j++)
                rot[k][j] = 0;
        end
        if (!is_zero)
        begin
            rs = 0;
            ls = 0;
            while ((mx >> rs) >= (64'd1 << 30))
                rs++;
            while ((mx << ls) < (64'd1 << 29))
                ls++;
            for (int i = 0; i < 4; i++)
                p[i] = (p[i] < 0) ? -longint'((mg[i] >> rs) << ls)
                                  : longint'((mg[i] >> rs) << ls);
            w2 = p[0] * p[0];
            x2 = p[1] * p[1];
            y2 = p[2] * p[2];
            z2 = p[3] * p[3];
            n = w2 + x2 + y2 + z2;
            rot[0][0] = norm_ratio(w2 + x2 - y2 - z2, n);
            rot[0][1] = norm_ratio(2 * (p[1] * p[2] - p[3] * p[0]), n);
            rot[0][2] = norm_ratio(2 * (p[1] * p[3] + p[2] * p[0]), n);
            rot[1][0] = norm_ratio(2 * (p[1] * p[2] + p[3] * p[0]), n);
            rot[1][1] = norm_ratio(w2 - x2 + y2 - z2, n);
            rot[1][2] = norm_ratio(2 * (p[2] * p[3] - p[1] * p[0]), n);
            rot[2][0] = norm_ratio(2 * (p[1] * p[3] - p[2] * p[0]), n);
            rot[2][1] = norm_ratio(2 * (p[2] * p[3] + p[1] * p[0]), n);
            rot[2][2] = norm_ratio(w2 - x2 - y2 + z2, n);
            for (int k = 0; k < 3; k++)
            begin
                s = rot[0][k] * longint'(tv[0]) + rot[1][k] * longint'(tv[1])
                    + rot[2][k] * longint'(tv[2]);
                cen[k] = centre_round(-s);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            e.row_index = k[1:0];
            e.col0 = rot[k][0][31:0];
            e.col1 = rot[k][1][31:0];
            e.col2 = rot[k][2][31:0];
            e.centre = cen[k][31:0];
            e.zero_length = is_zero;
            e.last_row = (k == 2);
            pending_rows = {pending_rows, e};
        end
    endfunction

    // Compares one received row with the oldest expected row.
    function void check_row(row_expect_t got);
        row_expect_t e;
        if (pending_rows.size() == 0)
        begin
            report("row with nothing expected", 0, 0);
            return;
        end
        e = pending_rows.pop_front();
        if (got.row_index !== e.row_index)
            report("row_index", got.row_index, e.row_index);
        if (got.col0 !== e.col0)
            report("entry_col0", got.col0, e.col0);
        if (got.col1 !== e.col1)
            report("entry_col1", got.col1, e.col1);
        if (got.col2 !== e.col2)
            report("entry_col2", got.col2, e.col2);
        if (got.centre !== e.centre)
            report("centre_component", got.centre, e.centre);
        if (got.zero_length !== e.zero_length)
            report("zero_length", got.zero_length, e.zero_length);
        if (got.last_row !== e.last_row)
            report("last_row", got.last_row, e.last_row);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    endfunction
endclass

module tb_quaternion_pose_to_rotation;
    import qptr_pkg::*;

    localparam int RANDOM_POSES = 208;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   sending_done;
    bit   long_hold;

    qptr_pose_if pose ();
    qptr_row_if  rows ();

    rotation_scoreboard board;

    quaternion_pose_to_rotation u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pose  (pose.sink),
        .rows  (rows.source)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Offers one pose and waits for its transfer; the score is noted at the edge.
    task automatic send_pose(logic signed [31:0] qv[4], logic signed [31:0] tv[3]);
        pose.valid   <= 1'b1;
        pose.quat_w  <= qv[0];
        pose.quat_x  <= qv[1];
        pose.quat_y  <= qv[2];
        pose.quat_z  <= qv[3];
        pose.trans_x <= tv[0];
        pose.trans_y <= tv[1];
        pose.trans_z <= tv[2];
        do
            @(posedge clk);
        while (!pose.ready);
        board.note_pose(qv, tv);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        pose.valid <= 1'b0;
        repeat (n)
            @(negedge clk);
    endtask

    // Random 32-bit value, biased toward extremes, small values and zero.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 8)) - 4);
            4: return 32'($urandom_range(0, 131071)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    // Directed poses, then random ones sent in bursts.
    initial
    begin
        logic signed [31:0] qv[4];
        logic signed [31:0] tv[3];
        int                 burst;
        logic [31:0]        one_q;
        board = new();
        sending_done = 1'b0;
        pose.valid   <= 1'b0;
        pose.quat_w  <= '0;
        pose.quat_x  <= '0;
        pose.quat_y  <= '0;
        pose.quat_z  <= '0;
        pose.trans_x <= '0;
        pose.trans_y <= '0;
        pose.trans_z <= '0;
        rst_n = 1'b0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        one_q = 32'h0001_0000;
        // Identity, unit axes, zero quaternion, smallest and largest magnitudes, extreme translations.
        for (int d = 0; d < 22; d++)
        begin
            for (int i = 0; i < 4; i++)
                qv[i] = 0;
            tv[0] = 32'h0003_0000;
            tv[1] = -32'sh0001_8000;
            tv[2] = 32'h0000_0001;
            case (d)
                0: qv[0] = one_q;
                1: qv[1] = one_q;
                2: qv[2] = one_q;
                3: qv[3] = one_q;
                4: ;
                5: begin tv[0] = 32'h8000_0000; tv[1] = 32'h7FFF_FFFF; end
                6: qv[0] = 32'h8000_0000;
                7: qv[3] = 32'h7FFF_FFFF;
                8: qv[1] = 32'h1;
                9: for (int i = 0; i < 4; i++) qv[i] = 32'h8000_0000;
                10: for (int i = 0; i < 4; i++) qv[i] = 32'h7FFF_FFFF;
                11: for (int i = 0; i < 4; i++) qv[i] = 32'h1;
                12:
                begin
                    qv[0] = 32'h7FFF_FFFF;
                    qv[1] = 32'h8000_0000;
                    for (int i = 0; i < 3; i++) tv[i] = 32'h8000_0000;
                end
                13:
                begin
                    qv[0] = one_q;
                    for (int i = 0; i < 3; i++) tv[i] = 32'h7FFF_FFFF;
                end
                14:
                begin
                    qv[2] = 32'h8000_0000;
                    for (int i = 0; i < 3; i++) tv[i] = 32'h8000_0000;
                end
                15: begin qv[0] = 32'h1; qv[2] = -32'sh1; end
                16: begin qv[1] = 32'h3FFF_FFFF; qv[2] = 32'h4000_0000; end
                17: begin qv[0] = 32'hFFFF_FFFF; qv[3] = 32'h0000_0003; end
                18: for (int i = 0; i < 4; i++) qv[i] = 32'h0000_8000;
                19: for (int i = 0; i < 3; i++) tv[i] = 32'hFFFF_FFFF;
                20: begin qv[0] = 32'h5555_5555; qv[1] = 32'hAAAA_AAAA; end
                default: begin qv[3] = -32'sh1; tv[2] = 32'h7FFF_FFFF; end
            endcase
            send_pose(qv, tv);
        end
        // Random poses in bursts, with idle gaps after some bursts.
        for (int sent = 0; sent < RANDOM_POSES; )
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_POSES; b++)
            begin
                for (int i = 0; i < 4; i++)
                    qv[i] = ($urandom_range(0, 29) == 0) ? 32'h0 : pick_word();
                for (int i = 0; i < 3; i++)
                    tv[i] = pick_word();
                send_pose(qv, tv);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 10));
        end
        pose.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver stalls: one long hold-off early, then always-ready stretches alternating with random stalls.
    initial
    begin
        long_hold = 1'b0;
        @(posedge rst_n);
        repeat (60)
            @(negedge clk);
        long_hold = 1'b1;
        repeat (400)
            @(negedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        int phase;
        rows.ready <= 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (long_hold)
                rows.ready <= 1'b0;
            else if ((phase / 200) % 3 == 0)
                rows.ready <= 1'b1;
            else
                rows.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Sample row transfers at the rising edge.
    always @(posedge clk)
    begin
        row_expect_t got;
        if (rst_n && rows.valid && rows.ready)
        begin
            got.row_index = rows.row_index;
            got.col0 = rows.entry_col0;
            got.col1 = rows.entry_col1;
            got.col2 = rows.entry_col2;
            got.centre = rows.centre_component;
            got.zero_length = rows.zero_length;
            got.last_row = rows.last_row;
            board.check_row(got);
        end
    end

    // End of run: drain, settle, then decide; the cycle counter guards against hangs.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        wait (sending_done);
        while (board.pending_rows.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (board.mismatches == 0 && board.pending_rows.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
